[src/gda_pkg.sv]
// Shared types, codes and calendar tables for the Gregorian date arithmetic core.
package gda_pkg;

    typedef enum logic [1:0] {
        ACT_VALIDATE = 2'd0,
        ACT_ADD      = 2'd1,
        ACT_SUB      = 2'd2,
        ACT_DIFF     = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_INVALID    = 3'd1,
        ST_BEFORE_ONE = 3'd2,
        ST_OVERFLOW   = 3'd3,
        ST_REF_LATER  = 3'd4
    } status_t;

    localparam int DAYS_PER_400Y = 146097;
    localparam int DAYS_PER_100Y = 36524;
    localparam int DAYS_PER_4Y   = 1461;
    localparam int DAYS_PER_YEAR = 365;

    // Length of a month in a common year; month number 1..12.
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m) inside
            4'd2:                      len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // Days in a common year before the first of month m; month number 1..12.
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] n;
        case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

[src/gda_if.sv]
// Valid/ready channels carrying date requests and date results.
interface gda_in_if #(
    parameter int YEAR_BITS      = 16,
    parameter int DAY_COUNT_BITS = 25
);
    logic                      valid;
    logic                      ready;
    logic [1:0]                action;
    logic [YEAR_BITS-1:0]      year;
    logic [3:0]                month;
    logic [4:0]                day;
    logic [DAY_COUNT_BITS-1:0] offset_days;
    logic [YEAR_BITS-1:0]      ref_year;
    logic [3:0]                ref_month;
    logic [4:0]                ref_day;

    modport source (
        output valid, action, year, month, day, offset_days, ref_year, ref_month, ref_day,
        input  ready
    );
    modport sink (
        input  valid, action, year, month, day, offset_days, ref_year, ref_month, ref_day,
        output ready
    );
endinterface

interface gda_out_if #(
    parameter int YEAR_BITS      = 16,
    parameter int DAY_COUNT_BITS = 25
);
    logic                      valid;
    logic                      ready;
    logic [YEAR_BITS-1:0]      out_year;
    logic [3:0]                out_month;
    logic [4:0]                out_day;
    logic [DAY_COUNT_BITS-1:0] day_count;
    logic [2:0]                status;

    modport source (
        output valid, out_year, out_month, out_day, day_count, status,
        input  ready
    );
    modport sink (
        input  valid, out_year, out_month, out_day, day_count, status,
        output ready
    );
endinterface

[src/gregorian_date_arithmetic_core.sv]
// Gregorian date arithmetic core: validate, add days, subtract days, day difference.
//
// in_ch carries one request per transfer: action, a date, a day offset and a
// reference date. out_ch returns one result per request, in request order:
// the resulting date (the input date on error or for validate/difference),
// the day count for the difference action and a status code.
// Throughput is one request per cycle while out_ch takes its results: three
// stages turn both dates into serial day numbers, one stage does the
// add/subtract/compare, six stages convert the serial day back to a date,
// and the last stage is the output register where the overflow check is
// applied.
// The whole pipeline advances together; when out_ch holds a result that is
// not taken, every stage holds and in_ch.ready drops in the same cycle, so
// nothing is lost or repeated. The block keeps no state between requests.
// Reset clears only the stage valid bits and the output valid.
module gregorian_date_arithmetic_core #(
    parameter int YEAR_BITS      = 16,
    parameter int DAY_COUNT_BITS = 25
) (
    input  logic       clk,
    input  logic       rst_n,
    gda_in_if.sink     in_ch,
    gda_out_if.source  out_ch
);
    localparam int SB     = YEAR_BITS + 9;
    localparam int W      = ((SB > DAY_COUNT_BITS) ? SB : DAY_COUNT_BITS) + 1;
    localparam int YW     = W - 8;
    localparam int NSTAGE = 10;

    typedef struct packed {
        logic [1:0]                action;
        logic [YEAR_BITS-1:0]      year;
        logic [3:0]                month;
        logic [4:0]                day;
        logic [DAY_COUNT_BITS-1:0] offset;
    } front_t;

    typedef struct packed {
        logic                      conv;
        gda_pkg::status_t          status;
        logic [DAY_COUNT_BITS-1:0] cnt;
        logic [YEAR_BITS-1:0]      year;
        logic [3:0]                month;
        logic [4:0]                day;
    } side_t;

    logic                      en;
    logic [NSTAGE-1:0]         vld_reg;
    logic                      out_valid_reg;
    front_t                    front_reg [3];
    side_t                     side_reg [7];
    logic [W-1:0]              n_reg;
    logic [YEAR_BITS-1:0]      out_year_reg;
    logic [3:0]                out_month_reg;
    logic [4:0]                out_day_reg;
    logic [DAY_COUNT_BITS-1:0] out_cnt_reg;
    gda_pkg::status_t          out_status_reg;

    logic [SB-1:0]             s_date;
    logic [SB-1:0]             s_ref;
    logic                      ok_date;
    logic                      ok_ref;
    front_t                    front_next;
    side_t                     side_next;
    logic [W-1:0]              n_next;
    logic [W-1:0]              s_w;
    logic [W-1:0]              off_w;
    logic [W-1:0]              gap_w;
    logic [YW-1:0]             f_year;
    logic [3:0]                f_month;
    logic [4:0]                f_day;
    side_t                     side_last;

    assign en          = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    assign front_next = '{action: in_ch.action, year: in_ch.year, month: in_ch.month,
                          day: in_ch.day, offset: in_ch.offset_days};

    gda_to_serial #(.YEAR_BITS(YEAR_BITS)) u_date (
        .clk    (clk),
        .en     (en),
        .year   (in_ch.year),
        .month  (in_ch.month),
        .day    (in_ch.day),
        .serial (s_date),
        .ok     (ok_date)
    );

    gda_to_serial #(.YEAR_BITS(YEAR_BITS)) u_ref (
        .clk    (clk),
        .en     (en),
        .year   (in_ch.ref_year),
        .month  (in_ch.ref_month),
        .day    (in_ch.ref_day),
        .serial (s_ref),
        .ok     (ok_ref)
    );

    // operation stage
    assign s_w   = W'(s_date);
    assign off_w = W'(front_reg[2].offset);
    assign gap_w = s_w - W'(s_ref);

    always_comb
    begin
        side_next.conv   = 1'b0;
        side_next.status = gda_pkg::ST_OK;
        side_next.cnt    = '0;
        side_next.year   = front_reg[2].year;
        side_next.month  = front_reg[2].month;
        side_next.day    = front_reg[2].day;
        n_next           = W'(1);
        if (!ok_date)
            side_next.status = gda_pkg::ST_INVALID;
        else
        begin
            case (front_reg[2].action)
                gda_pkg::ACT_ADD:
                begin
                    side_next.conv = 1'b1;
                    n_next         = s_w + off_w;
                end
                gda_pkg::ACT_SUB:
                begin
                    if (off_w >= s_w)
                        side_next.status = gda_pkg::ST_BEFORE_ONE;
                    else
                    begin
                        side_next.conv = 1'b1;
                        n_next         = s_w - off_w;
                    end
                end
                gda_pkg::ACT_DIFF:
                begin
                    if (!ok_ref)
                        side_next.status = gda_pkg::ST_INVALID;
                    else if (s_ref > s_date)
                        side_next.status = gda_pkg::ST_REF_LATER;
                    else if (gap_w > W'({DAY_COUNT_BITS{1'b1}}))
                        side_next.cnt = '1;
                    else
                        side_next.cnt = gap_w[DAY_COUNT_BITS-1:0];
                end
                default: ;
            endcase
        end
    end

    gda_from_serial #(.W(W)) u_conv (
        .clk    (clk),
        .en     (en),
        .serial (n_reg),
        .year   (f_year),
        .month  (f_month),
        .day    (f_day)
    );

    assign side_last = side_reg[6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[NSTAGE-2:0], in_ch.valid};
            out_valid_reg <= vld_reg[NSTAGE-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            front_reg[0] <= front_next;
            front_reg[1] <= front_reg[0];
            front_reg[2] <= front_reg[1];
            n_reg        <= n_next;
            side_reg[0]  <= side_next;
            for (int i = 1; i < 7; i++)
                side_reg[i] <= side_reg[i-1];

            out_cnt_reg <= side_last.cnt;
            if (side_last.conv && f_year[YW-1:YEAR_BITS] == '0)
            begin
                out_year_reg   <= f_year[YEAR_BITS-1:0];
                out_month_reg  <= f_month;
                out_day_reg    <= f_day;
                out_status_reg <= side_last.status;
            end
            else
            begin
                out_year_reg   <= side_last.year;
                out_month_reg  <= side_last.month;
                out_day_reg    <= side_last.day;
                out_status_reg <= side_last.conv ? gda_pkg::ST_OVERFLOW : side_last.status;
            end
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_year  = out_year_reg;
    assign out_ch.out_month = out_month_reg;
    assign out_ch.out_day   = out_day_reg;
    assign out_ch.day_count = out_cnt_reg;
    assign out_ch.status    = out_status_reg;

    a_cnt_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != gda_pkg::ST_OK |-> out_cnt_reg == '0)
        else $error("day count set on an error result");

    a_ok_date_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == gda_pkg::ST_OK |->
            out_month_reg >= 4'd1 && out_month_reg <= 4'd12 && out_day_reg != 5'd0)
        else $error("ok result carries an impossible date");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg) && out_valid_reg)
        else $error("pipeline moved during a stall");

endmodule

[src/gda_to_serial.sv]
// Three-stage date check and date-to-serial-day conversion (1-1-1 is day 1).
module gda_to_serial #(
    parameter int YEAR_BITS = 16
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [YEAR_BITS-1:0]   year,
    input  logic [3:0]             month,
    input  logic [4:0]             day,
    output logic [YEAR_BITS+8:0]   serial,
    output logic                   ok
);
    localparam int SB       = YEAR_BITS + 9;
    localparam int QB       = YEAR_BITS - 6;
    localparam int PW       = YEAR_BITS + 21;
    localparam int K100_SH  = 27;
    localparam int K100     = ((1 << K100_SH) + 99) / 100;

    // stage 1
    logic [YEAR_BITS-1:0] p_reg;
    logic [QB-1:0]        q100_reg;
    logic [3:0]           m1_reg;
    logic [4:0]           d1_reg;
    logic                 pre_reg;
    // stage 2
    logic [SB-1:0]        p365_reg;
    logic [YEAR_BITS-3:0] p4_reg;
    logic [QB-1:0]        q100b_reg;
    logic [3:0]           m2_reg;
    logic [4:0]           d2_reg;
    logic                 leap_reg;
    logic                 ok2_reg;
    // stage 3
    logic [SB-1:0]        serial_reg;
    logic                 ok_reg;

    logic [YEAR_BITS-1:0] p_next;
    logic [PW-1:0]        prod1;
    logic [YEAR_BITS-1:0] r100;
    logic                 leap_next;
    logic [4:0]           lim;
    logic [SB-1:0]        serial_next;

    assign p_next = year - YEAR_BITS'(1);
    assign prod1  = PW'(p_next) * PW'(K100);   // p / 100 by reciprocal

    assign r100      = p_reg - YEAR_BITS'(q100_reg) * YEAR_BITS'(100);
    assign leap_next = (p_reg[1:0] == 2'b11) &&
                       (r100 != YEAR_BITS'(99) || q100_reg[1:0] == 2'b11);
    assign lim       = (m1_reg == 4'd2 && leap_next) ? 5'd29 : gda_pkg::month_len(m1_reg);

    assign serial_next = p365_reg + SB'(p4_reg) - SB'(q100b_reg) + SB'(q100b_reg >> 2)
                       + SB'(gda_pkg::days_before(m2_reg)) + SB'(d2_reg)
                       + SB'(m2_reg > 4'd2 && leap_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg     <= p_next;
            q100_reg  <= prod1[K100_SH +: QB];
            m1_reg    <= month;
            d1_reg    <= day;
            pre_reg   <= (year != '0) && (month >= 4'd1) && (month <= 4'd12) && (day != 5'd0);

            p365_reg  <= SB'(p_reg) * SB'(365);
            p4_reg    <= p_reg[YEAR_BITS-1:2];
            q100b_reg <= q100_reg;
            m2_reg    <= m1_reg;
            d2_reg    <= d1_reg;
            leap_reg  <= leap_next;
            ok2_reg   <= pre_reg && (d1_reg <= lim);

            serial_reg <= serial_next;
            ok_reg     <= ok2_reg;
        end
    end

    assign serial = serial_reg;
    assign ok     = ok_reg;
endmodule

[src/gda_from_serial.sv]
// Six-stage serial-day-to-date conversion: 400/100/4/1-year split, then month search.
module gda_from_serial #(
    parameter int W = 26
) (
    input  logic           clk,
    input  logic           en,
    input  logic [W-1:0]   serial,
    output logic [W-9:0]   year,
    output logic [3:0]     month,
    output logic [4:0]     day
);
    localparam int YW     = W - 8;
    localparam int QW     = W - 16;
    localparam int PW     = 2 * W + 2;
    localparam int SH400  = W + 18;
    localparam logic [63:0] K400 = ((64'd1 << SH400) + 64'd146096) / 64'd146097;
    localparam int SH4    = 27;
    localparam int K4     = ((1 << SH4) + 1460) / 1461;

    // F1
    logic [W-1:0]  r_reg;
    logic [QW-1:0] q400a_reg;
    // F2
    logic [17:0]   r2_reg;
    logic [QW-1:0] q400b_reg;
    // F3
    logic [15:0]   r3_reg;
    logic [1:0]    ca_reg;
    logic [QW-1:0] q400c_reg;
    // F4
    logic [15:0]   r3b_reg;
    logic [4:0]    q4_reg;
    logic [1:0]    cb_reg;
    logic [QW-1:0] q400d_reg;
    // F5
    logic [8:0]    r5_reg;
    logic [1:0]    y1_reg;
    logic [4:0]    q4b_reg;
    logic [1:0]    cc_reg;
    logic [QW-1:0] q400e_reg;
    // F6
    logic [YW-1:0] year_reg;
    logic [3:0]    month_reg;
    logic [4:0]    day_reg;

    logic [W-1:0]  r_next;
    logic [PW-1:0] prod400;
    logic [W-1:0]  rem400;
    logic [1:0]    c_next;
    logic [17:0]   c_days;
    logic [33:0]   prod4;
    logic [15:0]   rem4;
    logic [10:0]   r4;
    logic [1:0]    y1_next;
    logic [10:0]   y1_days;
    logic [YW-1:0] year_next;
    logic          lp;
    logic [8:0]    yd;
    logic [8:0]    base;
    logic [8:0]    base_sel;
    logic [3:0]    mi;

    assign r_next  = serial - W'(1);
    assign prod400 = PW'(r_next) * PW'(K400);
    assign rem400  = r_reg - W'(q400a_reg) * W'(gda_pkg::DAYS_PER_400Y);

    always_comb
    begin
        if (r2_reg >= 18'd109572)
            c_next = 2'd3;
        else if (r2_reg >= 18'd73048)
            c_next = 2'd2;
        else if (r2_reg >= 18'd36524)
            c_next = 2'd1;
        else
            c_next = 2'd0;
        c_days = 18'(c_next) * 18'(gda_pkg::DAYS_PER_100Y);
    end

    assign prod4 = 34'(r3_reg) * 34'(K4);
    assign rem4  = r3b_reg - 16'(q4_reg) * 16'(gda_pkg::DAYS_PER_4Y);
    assign r4    = rem4[10:0];

    always_comb
    begin
        if (r4 >= 11'd1095)
            y1_next = 2'd3;
        else if (r4 >= 11'd730)
            y1_next = 2'd2;
        else if (r4 >= 11'd365)
            y1_next = 2'd1;
        else
            y1_next = 2'd0;
        y1_days = 11'(y1_next) * 11'(gda_pkg::DAYS_PER_YEAR);
    end

    assign year_next = YW'(q400e_reg) * YW'(400) + YW'(cc_reg) * YW'(100)
                     + YW'(q4b_reg) * YW'(4) + YW'(y1_reg) + YW'(1);
    // last year of a 4-year block is leap, except a century year not divisible by 400
    assign lp = (y1_reg == 2'd3) && (q4b_reg != 5'd24 || cc_reg == 2'd3);
    assign yd = r5_reg + 9'd1;

    always_comb
    begin
        mi       = 4'd0;
        base_sel = 9'd0;
        for (int i = 1; i < 12; i++)
        begin
            base = gda_pkg::days_before(4'(i + 1)) + 9'((i >= 2) && lp);
            if (yd > base)
            begin
                mi       = 4'(i);
                base_sel = base;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg     <= r_next;
            q400a_reg <= prod400[SH400 +: QW];

            r2_reg    <= rem400[17:0];
            q400b_reg <= q400a_reg;

            r3_reg    <= 16'(r2_reg - c_days);
            ca_reg    <= c_next;
            q400c_reg <= q400b_reg;

            r3b_reg   <= r3_reg;
            q4_reg    <= prod4[SH4 +: 5];
            cb_reg    <= ca_reg;
            q400d_reg <= q400c_reg;

            r5_reg    <= 9'(r4 - y1_days);
            y1_reg    <= y1_next;
            q4b_reg   <= q4_reg;
            cc_reg    <= cb_reg;
            q400e_reg <= q400d_reg;

            year_reg  <= year_next;
            month_reg <= mi + 4'd1;
            day_reg   <= 5'(yd - base_sel);
        end
    end

    assign year  = year_reg;
    assign month = month_reg;
    assign day   = day_reg;
endmodule
